// ----- hw/rtl/circular_deque_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Circular deque unit assertion macros
// Shared concurrent assertion forms for the deque checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Property that must hold in the same cycle.
`define CDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular deque package
// Transaction types, command and status codes, and cell control types.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] PEEK_EMPTY = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5
   } cdq_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } cdq_status_type;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [DATA_W-1:0] data_in;
   } cdq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [1:0]               status;
      logic                     is_empty;
      logic                     is_full;
   } cdq_rsp_type;

   // What every cell of a chain does at the next edge.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_LO,
      CELL_FROM_HI,
      CELL_LOAD_TAIL
   } cdq_cell_op_type;

   typedef struct packed {
      cdq_cell_op_type   op;
      logic [DATA_W-1:0] data;
   } cdq_cell_ctl_type;

endpackage

// ----- hw/rtl/cdq_cell.sv -----
// ----------------------------------------------------------------------------
// Circular deque cell
// One storage position of a chain: holds, shifts from a neighbor, or loads.
// ----------------------------------------------------------------------------
module cdq_cell
   import cdq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  cdq_cell_ctl_type             ctl,
   input  logic [$clog2(DEPTH+1)-1:0]   pos,
   input  logic [DATA_W-1:0]            lo_data,
   input  logic [DATA_W-1:0]            hi_data,
   output logic [DATA_W-1:0]            data
);

   localparam int CNT_W = $clog2(DEPTH+1);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         CELL_FROM_LO:   data_in = lo_data;
         CELL_FROM_HI:   data_in = hi_data;
         CELL_LOAD_TAIL: begin
            if (pos == CNT_W'(INDEX)) begin
               data_in = ctl.data;
            end
         end
         default:        data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- hw/rtl/cdq_chain.sv -----
// ----------------------------------------------------------------------------
// Circular deque chain
// Row of cells ordered from one end of the deque; cell 0 is that end.
// ----------------------------------------------------------------------------
module cdq_chain
   import cdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  cdq_cell_ctl_type             ctl,
   input  logic [$clog2(DEPTH+1)-1:0]   pos,
   output logic [DATA_W-1:0]            end_data
);

   logic [DATA_W-1:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] lo_data;
      logic [DATA_W-1:0] hi_data;

      if (i == 0) begin : g_first
         assign lo_data = ctl.data;
      end else begin : g_lo
         assign lo_data = cell_data[i-1];
      end

      // last cell has no upper neighbor: hold
      if (i == DEPTH - 1) begin : g_last
         assign hi_data = cell_data[i];
      end else begin : g_hi
         assign hi_data = cell_data[i+1];
      end

      cdq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .pos     (pos),
         .lo_data (lo_data),
         .hi_data (hi_data),
         .data    (cell_data[i])
      );
   end

   assign end_data = cell_data[0];

endmodule

// ----- hw/rtl/circular_deque_unit.sv -----
// ----------------------------------------------------------------------------
// Circular deque unit
// Double-ended queue of signed 32-bit values with a programmable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one command per transaction (push/pop/peek at front or rear).
//   rsp_ returns exactly one result per command: peeked value, status and the
//   empty/full flags after the command.
//   Each accepted command's result is registered before rsp_valid; one command
//   is taken every cycle unless req_stall is high. The two cell chains apply a
//   shift or a tail load in their own registers, in step with the result register.
//   The front chain keeps the front value in cell 0, the rear chain keeps the
//   rear value in cell 0, so both peeks read a fixed cell.
//   A held result (rsp_stall high) stalls req_ the same cycle; the result
//   register stays unchanged until taken.
//   csr_write_en writes the capacity (0 acts as 1, values above DEPTH act as
//   DEPTH) and empties the deque; write only while no transaction is pending.
//   req_ is stalled in the cycle of a capacity write.
//   Synchronous reset empties the deque, sets capacity to 16 (or DEPTH if
//   smaller) and drops any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_deque_unit
   import cdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cdq_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cdq_rsp_type       rsp_data,
   input  logic              csr_write_en,
   input  logic [CAP_W-1:0]  csr_write_data
);

   localparam int CNT_W     = $clog2(DEPTH+1);
   localparam int RESET_CAP = (int'(CAP_RESET) > DEPTH) ? DEPTH : int'(CAP_RESET);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cdq_rsp_type      rsp_data_ff, rsp_data_in;

   cdq_cell_ctl_type  fwd_ctl, rev_ctl;
   logic [DATA_W-1:0] front_data, rear_data;
   logic              accept, empty, full;
   cdq_status_type    status;
   logic [DATA_W-1:0] peek;

   cdq_chain #(.DEPTH(DEPTH)) u_front_chain (
      .clock    (clock),
      .ctl      (fwd_ctl),
      .pos      (count_ff),
      .end_data (front_data)
   );

   cdq_chain #(.DEPTH(DEPTH)) u_rear_chain (
      .clock    (clock),
      .ctl      (rev_ctl),
      .pos      (count_ff),
      .end_data (rear_data)
   );

   // hold the command while a result waits or the capacity is being written
   assign req_stall = (rsp_valid_ff && rsp_stall) || csr_write_en;
   assign accept    = req_valid && !req_stall;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == cap_ff);

   always_comb begin
      count_in     = count_ff;
      cap_in       = cap_ff;
      fwd_ctl.op   = CELL_HOLD;
      fwd_ctl.data = req_data.data_in;
      rev_ctl.op   = CELL_HOLD;
      rev_ctl.data = req_data.data_in;
      status       = ST_OK;
      peek         = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_write_en) begin
         if (csr_write_data == '0) begin
            cap_in = CNT_W'(1);
         end else if (int'(csr_write_data) > DEPTH) begin
            cap_in = CNT_W'(DEPTH);
         end else begin
            cap_in = CNT_W'(csr_write_data);
         end
         count_in = '0;
      end else if (accept) begin
         unique case (req_data.opcode)
            OP_PUSH_FRONT: begin
               if (full) begin
                  status = ST_OVERFLOW;
               end else begin
                  fwd_ctl.op = CELL_FROM_LO;
                  rev_ctl.op = CELL_LOAD_TAIL;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            OP_PUSH_REAR: begin
               if (full) begin
                  status = ST_OVERFLOW;
               end else begin
                  fwd_ctl.op = CELL_LOAD_TAIL;
                  rev_ctl.op = CELL_FROM_LO;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status = ST_UNDERFLOW;
               end else begin
                  fwd_ctl.op = CELL_FROM_HI;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            OP_POP_REAR: begin
               if (empty) begin
                  status = ST_UNDERFLOW;
               end else begin
                  rev_ctl.op = CELL_FROM_HI;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            OP_PEEK_FRONT: begin
               if (empty) begin
                  status = ST_UNDERFLOW;
                  peek   = PEEK_EMPTY;
               end else begin
                  peek = front_data;
               end
            end
            OP_PEEK_REAR: begin
               if (empty) begin
                  status = ST_UNDERFLOW;
                  peek   = PEEK_EMPTY;
               end else begin
                  peek = rear_data;
               end
            end
            default: begin
               // unknown command: report current flags, change nothing
            end
         endcase
         rsp_valid_in         = 1'b1;
         rsp_data_in.data_out = peek;
         rsp_data_in.status   = status;
         rsp_data_in.is_empty = (count_in == '0);
         rsp_data_in.is_full  = (count_in == cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CNT_W'(RESET_CAP);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// Circular deque checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_deque_unit_defines.svh"

module cdq_checker
   import cdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  cdq_rsp_type       rsp_data
);

   logic [DATA_W-1:0] out_value;
   logic              held;
   logic              both_flags;
   logic              overflow_ok;
   logic              underflow_ok;

   assign out_value  = rsp_data.data_out;
   assign held       = rsp_valid && rsp_stall;
   assign both_flags = rsp_valid && rsp_data.is_empty && rsp_data.is_full;

   assign overflow_ok  = !(rsp_valid && rsp_data.status == ST_OVERFLOW) ||
                         (rsp_data.is_full && out_value == '0);
   assign underflow_ok = !(rsp_valid && rsp_data.status == ST_UNDERFLOW) ||
                         (rsp_data.is_empty && (out_value == '0 || out_value == PEEK_EMPTY));

   `CDQ_ASSERT_NEXT(a_rsp_hold, clock, reset, held, rsp_valid && $stable(rsp_data), "result moved")

   `CDQ_ASSERT(a_flags_exclusive, clock, reset, !both_flags, "empty and full together")

   `CDQ_ASSERT(a_overflow_full, clock, reset, overflow_ok, "overflow without a full deque")

   `CDQ_ASSERT(a_underflow_empty, clock, reset, underflow_ok, "underflow without an empty deque")

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque unit testbench
// Runs directed and random deque commands over several capacities through
// both stalling channels. A shadow deque predicts each result, and the
// monitor compares every returned result against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import cdq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 200;

   // Opcodes outside the command set; the unit must leave the deque alone.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam logic [DATA_W-1:0] DATA_MAX  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] DATA_MIN  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] DATA_ONES = 32'hFFFF_FFFF;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   cdq_req_type       req_data       = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   cdq_rsp_type       rsp_data;
   logic              csr_write_en   = 1'b0;
   logic [CAP_W-1:0]  csr_write_data = '0;

   cdq_req_type command_queue[$];
   cdq_rsp_type expected_results[$];
   int          error_count = 0;
   int          cycle_count = 0;

   int req_gap_left   = 0;
   int req_calm_left  = 0;
   int rsp_stall_left = 0;
   int rsp_calm_left  = 0;
   int rsp_hold_left  = 0;
   int hold_requests  = 0;
   int hold_requests_served = 0;

   // Shadow deque
   logic [DATA_W-1:0] shadow_slots[DEPTH];
   logic [3:0]        front_idx       = '0;
   logic [3:0]        rear_idx        = '0;
   logic              deque_empty     = 1'b1;
   logic [CAP_W-1:0]  shadow_capacity = CAP_RESET;

   circular_deque_unit #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [CAP_W-1:0] slots_in_use();
      if (shadow_capacity == '0) return 5'd1;
      if (shadow_capacity > 5'(DEPTH)) return 5'(DEPTH);
      return shadow_capacity;
   endfunction

   function automatic logic deque_is_full();
      logic [CAP_W-1:0] used;
      used = slots_in_use();
      if (deque_empty) return 1'b0;
      // widen both indices so that rear + 1 does not wrap
      return (front_idx == 4'd0 && {1'b0, rear_idx} == used - 5'd1) ||
             ({1'b0, front_idx} == {1'b0, rear_idx} + 5'd1);
   endfunction

   function automatic cdq_rsp_type run_deque_command(cdq_req_type cmd);
      cdq_rsp_type      result;
      logic [CAP_W-1:0] used;
      logic [3:0]       last;
      used   = slots_in_use();
      last   = 4'(used - 5'd1);
      result = '0;
      result.status = ST_OK;
      case (cmd.opcode)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (deque_is_full()) begin
               result.status = ST_OVERFLOW;
            end else if (deque_empty) begin
               front_idx       = '0;
               rear_idx        = '0;
               deque_empty     = 1'b0;
               shadow_slots[0] = cmd.data_in;
            end else if (cmd.opcode == OP_PUSH_FRONT) begin
               front_idx = (front_idx == 4'd0) ? last : front_idx - 4'd1;
               shadow_slots[front_idx] = cmd.data_in;
            end else begin
               rear_idx = (rear_idx == last) ? 4'd0 : rear_idx + 4'd1;
               shadow_slots[rear_idx] = cmd.data_in;
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (deque_empty) begin
               result.status = ST_UNDERFLOW;
            end else if (front_idx == rear_idx) begin
               front_idx   = '0;
               rear_idx    = '0;
               deque_empty = 1'b1;
            end else if (cmd.opcode == OP_POP_FRONT) begin
               front_idx = (front_idx == last) ? 4'd0 : front_idx + 4'd1;
            end else begin
               rear_idx = (rear_idx == 4'd0) ? last : rear_idx - 4'd1;
            end
         end
         OP_PEEK_FRONT, OP_PEEK_REAR: begin
            if (deque_empty) begin
               result.status   = ST_UNDERFLOW;
               result.data_out = PEEK_EMPTY;
            end else begin
               result.data_out = (cmd.opcode == OP_PEEK_FRONT) ? shadow_slots[front_idx]
                                                               : shadow_slots[rear_idx];
            end
         end
         default: begin
         end
      endcase
      result.is_empty = deque_empty;
      result.is_full  = deque_is_full();
      return result;
   endfunction

   function automatic void check_result(cdq_rsp_type got);
      cdq_rsp_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result: data_out %0d status %0d", got.data_out, got.status);
         error_count++;
         return;
      end
      want = expected_results.pop_front();
      if (got.data_out !== want.data_out) begin
         $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
         error_count++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         error_count++;
      end
      if (got.is_empty !== want.is_empty) begin
         $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
         error_count++;
      end
      if (got.is_full !== want.is_full) begin
         $error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
         error_count++;
      end
   endfunction

   // Mostly short gaps, a few long ones, and now and then a calm stretch.
   function automatic int idle_length(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 100);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 39))
         0:       return '0;
         1:       return DATA_MAX;
         2:       return DATA_MIN;
         3:       return DATA_ONES;
         default: return $urandom;
      endcase
   endfunction

   // Bias the mix per segment so that the deque swings between full and empty.
   function automatic logic [2:0] pick_opcode(int mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
      case (mode)
         0: begin
            if (r < 70) return ($urandom_range(0, 1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            if (r < 85) return ($urandom_range(0, 1) != 0) ? OP_PEEK_REAR : OP_PEEK_FRONT;
            return ($urandom_range(0, 1) != 0) ? OP_POP_REAR : OP_POP_FRONT;
         end
         1: begin
            if (r < 65) return ($urandom_range(0, 1) != 0) ? OP_POP_REAR : OP_POP_FRONT;
            if (r < 85) return ($urandom_range(0, 1) != 0) ? OP_PEEK_REAR : OP_PEEK_FRONT;
            return ($urandom_range(0, 1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
         end
         default: return 3'($urandom_range(0, 5));
      endcase
   endfunction

   task automatic queue_command(logic [2:0] op, logic [DATA_W-1:0] value);
      cdq_req_type cmd;
      cmd.opcode  = op;
      cmd.data_in = value;
      command_queue.push_back(cmd);
   endtask

   task automatic queue_random(int count);
      int mode;
      int segment_left;
      segment_left = 0;
      mode         = 0;
      repeat (count) begin
         if (segment_left == 0) begin
            mode         = $urandom_range(0, 2);
            segment_left = $urandom_range(10, 60);
         end
         segment_left--;
         queue_command(pick_opcode(mode), pick_value());
      end
   endtask

   task automatic wait_drained();
      while (command_queue.size() != 0 || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      shadow_capacity = value;
      front_idx       = '0;
      rear_idx        = '0;
      deque_empty     = 1'b1;
   endtask

   // Sender: account for the transaction at the rising edge, drive at the falling edge.
   always @(posedge clock) begin : req_driver
      bit taken;
      taken = !reset && req_valid && !req_stall;
      if (taken) begin
         void'(command_queue.pop_front());
         expected_results.push_back(run_deque_command(req_data));
         req_gap_left = idle_length(req_calm_left);
      end
      @(negedge clock);
      // hold a stalled payload as it is
      if (!req_valid || taken) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (command_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= command_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      bit took;
      took = !reset && rsp_valid && !rsp_stall;
      if (took) check_result(rsp_data);
      @(negedge clock);
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
      end else if (took) begin
         rsp_stall_left = idle_length(rsp_calm_left);
      end else if (!rsp_valid && $urandom_range(0, 15) == 0) begin
         rsp_stall_left = $urandom_range(1, 4);
      end
      rsp_stall <= (rsp_hold_left > 0) || (rsp_stall_left > 0);
   end

   // Long receiver hold-off, started on request from the stimulus.
   always @(posedge clock) begin : rsp_hold_timer
      if (hold_requests != hold_requests_served) begin
         hold_requests_served = hold_requests;
         rsp_hold_left        = HOLD_CYCLES;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** circular_deque_unit: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0] phase_caps[9];
      logic [CAP_W-1:0] cap;
      phase_caps = '{5'd2, 5'd31, 5'd1, 5'd16, 5'd3, 5'd17, 5'd0, 5'd7, 5'd5};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty deque at reset capacity, extremes, and removal of the last value
      queue_command(OP_PEEK_FRONT, DATA_ONES);
      queue_command(OP_PEEK_REAR,  '0);
      queue_command(OP_POP_FRONT,  DATA_MAX);
      queue_command(OP_POP_REAR,   DATA_MIN);
      queue_command(OP_PUSH_FRONT, DATA_MAX);
      queue_command(OP_PUSH_REAR,  DATA_MIN);
      queue_command(OP_PEEK_FRONT, '0);
      queue_command(OP_PEEK_REAR,  '0);
      queue_command(OP_PUSH_FRONT, '0);
      queue_command(OP_PUSH_REAR,  DATA_ONES);
      queue_command(OP_POP_FRONT,  '0);
      queue_command(OP_POP_REAR,   '0);
      queue_command(OP_PEEK_FRONT, '0);
      queue_command(OP_PEEK_REAR,  '0);
      queue_command(OP_POP_REAR,   '0);
      queue_command(OP_POP_FRONT,  '0);
      queue_command(OP_SPARE_6,    DATA_ONES);
      queue_command(OP_PUSH_REAR,  32'h5A5A_A5A5);
      queue_command(OP_SPARE_7,    DATA_MAX);
      queue_command(OP_POP_FRONT,  '0);
      wait_drained();

      // Capacity zero acts as one slot: full after a single push
      write_capacity(5'd0);
      queue_command(OP_PUSH_REAR,  32'h1234_5678);
      queue_command(OP_PUSH_FRONT, DATA_MIN);
      queue_command(OP_PEEK_FRONT, '0);
      queue_command(OP_PEEK_REAR,  '0);
      queue_command(OP_POP_REAR,   '0);
      queue_command(OP_POP_FRONT,  '0);
      wait_drained();

      for (int i = 0; i < 9; i++) begin
         cap = (i == 8) ? 5'($urandom_range(0, 31)) : phase_caps[i];
         write_capacity(cap);
         queue_random(PHASE_ITEMS);
         // back up the result channel while commands keep coming
         if (i == 1 || i == 2) begin
            @(negedge clock);
            hold_requests++;
         end
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("** circular_deque_unit: PASSED **");
      end else begin
         $display("** circular_deque_unit: FAILED **");
      end
      $finish;
   end

endmodule
